// ----- sv/msrle_pkg.sv -----
// ----------------------------------------------------------------------------
// msrle_pkg
// Shared types and constants of the masked sample run-length encoder.
// ----------------------------------------------------------------------------
package msrle_pkg;

   // run and time counters
   localparam int MAX_RUN    = 65500;
   localparam int RUN_WIDTH  = 16;
   localparam int TIME_WIDTH = 32;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 8;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CHANNEL_MASK = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PIN_SHIFT    = CSR_INDEX_WIDTH'(1);
   localparam logic [7:0] CHANNEL_MASK_RESET = 8'hff;
   localparam logic [2:0] PIN_SHIFT_RESET    = 3'd0;

   // packet queue between front and back
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] sample;
      logic       last_sample;
   } req_type;

   typedef struct packed {
      logic [7:0]  level;
      logic [31:0] end_time;
      logic        stream_end;
   } rsp_type;

   // up to two packets written per transfer, first slot filled first
   typedef struct packed {
      logic    first_valid;
      logic    second_valid;
      rsp_type first_pkt;
      rsp_type second_pkt;
   } push_type;

   typedef struct packed {
      logic room_for_two;
      logic not_empty;
   } queue_status_type;

endpackage

// ----- sv/masked_sample_run_length_encoder.sv -----
// ----------------------------------------------------------------------------
// masked_sample_run_length_encoder: packets pass the queue, then the output register.
// Throughput one sample per cycle while req_ready is high; rsp gives one packet per
// cycle while rsp_ready is high; a 4-entry queue takes the two packets a final sample
// can close, and req_ready drops while the queue holds more than two packets. Synchronous
// reset clears run, queue and output; channel_mask resets to 0xff, pin_shift to 0.
// ----------------------------------------------------------------------------
module masked_sample_run_length_encoder import msrle_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_type                    rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   push_type         push;
   queue_status_type queue_status;
   rsp_type          head;
   logic             pop;

   // sample classification and run tracking
   msrle_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .queue_status (queue_status),
      .push         (push)
   );

   // packet queue
   msrle_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (queue_status)
   );

   // output register
   msrle_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule

// ----- sv/msrle_front.sv -----
// ----------------------------------------------------------------------------
// msrle_front
// Holds the configuration and the open run, and turns each sample into zero,
// one or two closed-run packets for the queue.
// ----------------------------------------------------------------------------
module msrle_front import msrle_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_type                    req_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  queue_status_type           queue_status,
   output push_type                   push
);

   logic [7:0]            channel_mask_ff;
   logic [2:0]            pin_shift_ff;
   logic [7:0]            run_level_ff, run_level_in;
   logic [RUN_WIDTH-1:0]  run_count_ff, run_count_in;
   logic [TIME_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic                  run_active_ff, run_active_in;

   logic                  accept;
   logic [7:0]            value;
   logic                  change;
   logic                  close;
   logic [RUN_WIDTH-1:0]  count_next;
   logic [TIME_WIDTH-1:0] elapsed_next;
   rsp_type               old_pkt, new_pkt;

   assign csr_ready = 1'b1;
   assign req_ready = queue_status.room_for_two;
   assign accept    = req_valid & req_ready;

   // configuration registers, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         channel_mask_ff <= CHANNEL_MASK_RESET;
         pin_shift_ff    <= PIN_SHIFT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CHANNEL_MASK: channel_mask_ff <= csr_wdata[7:0];
            CSR_PIN_SHIFT:    pin_shift_ff    <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // classify the sample against the open run
   always_comb begin
      value        = (req_data.sample & channel_mask_ff) << pin_shift_ff;
      change       = run_active_ff && (value != run_level_ff);
      count_next   = (!run_active_ff || change) ? RUN_WIDTH'(1)
                                                : run_count_ff + RUN_WIDTH'(1);
      elapsed_next = elapsed_ff + TIME_WIDTH'(1);
      close        = req_data.last_sample || (32'(count_next) >= 32'(MAX_RUN));

      old_pkt.level      = run_level_ff;
      old_pkt.end_time   = 32'(elapsed_ff);
      old_pkt.stream_end = 1'b0;
      new_pkt.level      = value;
      new_pkt.end_time   = 32'(elapsed_next);
      new_pkt.stream_end = req_data.last_sample;

      push.first_valid  = accept && (change || close);
      push.second_valid = accept && change && close;
      push.first_pkt    = change ? old_pkt : new_pkt;
      push.second_pkt   = new_pkt;

      run_active_in = !close;
      run_level_in  = value;
      run_count_in  = close ? '0 : count_next;
      elapsed_in    = req_data.last_sample ? '0 : elapsed_next;
   end

   // run state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_active_ff <= 1'b0;
         run_level_ff  <= '0;
         run_count_ff  <= '0;
         elapsed_ff    <= '0;
      end else if (accept) begin
         run_active_ff <= run_active_in;
         run_level_ff  <= run_level_in;
         run_count_ff  <= run_count_in;
         elapsed_ff    <= elapsed_in;
      end
   end

endmodule

// ----- sv/msrle_queue.sv -----
// ----------------------------------------------------------------------------
// msrle_queue
// Short packet queue: takes up to two packets per cycle, gives one per cycle while the output register pops.
// ----------------------------------------------------------------------------
module msrle_queue import msrle_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  push_type         push,
   input  logic             pop,
   output rsp_type          head,
   output queue_status_type status
);

   rsp_type                    mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0] count_ff, count_in;
   logic [1:0]                 push_num;

   // pointer and fill count update
   always_comb begin
      push_num  = {1'b0, push.first_valid} + {1'b0, push.second_valid};
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_WIDTH'(push_num);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_WIDTH'(pop);
      count_in  = count_ff + QUEUE_CNT_WIDTH'(push_num) - QUEUE_CNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // packet storage
   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         mem[wr_ptr_ff] <= push.first_pkt;
      end
      if (push.second_valid) begin
         mem[wr_ptr_ff + QUEUE_PTR_WIDTH'(1)] <= push.second_pkt;
      end
   end

   assign head                = mem[rd_ptr_ff];
   assign status.not_empty    = (count_ff != '0);
   assign status.room_for_two = (count_ff <= QUEUE_CNT_WIDTH'(QUEUE_DEPTH - 2));

endmodule

// ----- sv/msrle_back.sv -----
// ----------------------------------------------------------------------------
// msrle_back
// Output register: pulls packets from the queue and presents them on rsp.
// ----------------------------------------------------------------------------
module msrle_back import msrle_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type queue_status,
   input  rsp_type          head,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data
);

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   logic    load;

   // refill when the register is empty or its packet leaves this cycle
   assign load         = !rsp_valid_ff || rsp_ready;
   assign pop          = load && queue_status.not_empty;
   assign rsp_valid_in = load ? queue_status.not_empty : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= head;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
